FILE: hw/rtl/target_to_body_frame_core_assert.svh
// Assertion macros shared by the target-to-body-frame RTL
`ifndef TARGET_TO_BODY_FRAME_CORE_ASSERT_SVH
`define TARGET_TO_BODY_FRAME_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property at every enabled clock edge
`define TTBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ttbf check failed");
// Check that a condition leads to a consequence in the next cycle
`define TTBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttbf check failed");
`else
`define TTBF_ASSERT(lbl, clk, rst_n, prop)
`define TTBF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/ttbf_pkg.sv
// Shared constants, arctan table and gain helper for the target-to-body-frame core
package ttbf_pkg;

  localparam int DEF_ITERATIONS  = 16;
  localparam int DEF_COORD_WIDTH = 24;
  localparam int GUARD           = 8;
  localparam int HEADING_W       = 16;
  localparam int ANGLE_W         = 32;
  localparam int ATAN_ENTRIES    = 24;

  // Binary angle marks in heading units
  localparam logic [HEADING_W-1:0] QUARTER_H       = HEADING_W'(1) << (HEADING_W - 2);
  localparam logic [HEADING_W-1:0] HALF_H          = HEADING_W'(1) << (HEADING_W - 1);
  localparam logic [HEADING_W-1:0] THREE_QUARTER_H = QUARTER_H | HALF_H;

  // atan(2^-i) in 32-bit binary angle units, truncated
  localparam logic [ANGLE_W-1:0] ATAN_UNITS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41721,     32'd20860,
    32'd10430,     32'd5215,      32'd2607,      32'd1303,
    32'd651,       32'd325,       32'd162,       32'd81
  };

  // CORDIC gain in Q30: integer square root of the Q60 squared gain
  function automatic logic [63:0] gain_root(input int n);
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] res;
    logic [63:0] bit_v;
    p = 64'd1 << 60;
    for (int i = 0; i < n; i++) begin
      p = p + (p >> (2 * i));
    end
    num   = p;
    res   = '0;
    bit_v = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (num >= res + bit_v) begin
        num = num - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (res == 64'd0) begin
      res = 64'd1;
    end
    return res;
  endfunction

endpackage

FILE: hw/rtl/target_to_body_frame_core.sv
// Target-to-body-frame CORDIC core: rotates (target - position) by minus the heading.
// Throughput: one transaction per cycle while the skid slot is free; one cell per arctan
// step plus four scaling stages, each registered, behind a registered entry stage.
// A two-entry output register with skid slot lets the pipeline run while a result waits.
// Reset clears the valid pipeline, the output register and the skid slot; data is not reset.
`include "target_to_body_frame_core_assert.svh"
module target_to_body_frame_core #(
  parameter int ITERATIONS  = ttbf_pkg::DEF_ITERATIONS,
  parameter int COORD_WIDTH = ttbf_pkg::DEF_COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [COORD_WIDTH-1:0]         in_target_x,
  input  logic signed [COORD_WIDTH-1:0]         in_target_y,
  input  logic signed [COORD_WIDTH-1:0]         in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]         in_pos_y,
  input  logic signed [ttbf_pkg::HEADING_W-1:0] in_heading,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [COORD_WIDTH+1:0]         out_forward_offset,
  output logic signed [COORD_WIDTH+1:0]         out_lateral_offset
);
  import ttbf_pkg::*;

  localparam int OUT_W = COORD_WIDTH + 2;
  localparam int CW    = COORD_WIDTH + GUARD + 4;
  localparam int DEPTH = ITERATIONS + 5;
  localparam logic [63:0] GAIN_ROOT = gain_root(ITERATIONS);
  localparam logic [31:0] GAIN_K    = 32'((64'd1 << 62) / GAIN_ROOT);

  logic                         adv;
  logic [DEPTH-1:0]             vld_r;
  logic [HEADING_W-1:0]         z_raw;
  logic [HEADING_W-1:0]         z_rot;
  logic                         flip;
  logic signed [COORD_WIDTH-1:0] ax, bx, ay, by;
  logic signed [COORD_WIDTH:0]  dx_nxt, dy_nxt;
  logic signed [CW-1:0]         x0_r, y0_r;
  logic signed [ANGLE_W-1:0]    z0_r;

  logic signed [CW-1:0]         x_c [ITERATIONS+1];
  logic signed [CW-1:0]         y_c [ITERATIONS+1];
  logic signed [ANGLE_W-1:0]    z_c [ITERATIONS+1];

  logic signed [OUT_W-1:0]      fwd_tail, lat_tail;
  logic                         tail_v;
  logic                         out_valid_r, out_valid_nxt;
  logic                         skid_v_r, skid_v_nxt;
  logic                         out_take;
  logic                         load_out, load_skid, out_from_skid;
  logic signed [OUT_W-1:0]      out_fwd_r, out_lat_r;
  logic signed [OUT_W-1:0]      skid_fwd_r, skid_lat_r;

  // Pipeline moves whenever the skid slot is free
  assign adv      = !skid_v_r;
  assign in_stall = skid_v_r;

  // Negate the heading and fold it into [-pi/2, pi/2] with a vector flip
  always_comb begin
    z_raw  = '0 - $unsigned(in_heading);
    flip   = (z_raw > QUARTER_H) && (z_raw < THREE_QUARTER_H);
    z_rot  = flip ? (z_raw ^ HALF_H) : z_raw;
    ax     = flip ? in_pos_x : in_target_x;
    bx     = flip ? in_target_x : in_pos_x;
    ay     = flip ? in_pos_y : in_target_y;
    by     = flip ? in_target_y : in_pos_y;
    dx_nxt = {ax[COORD_WIDTH-1], ax} - {bx[COORD_WIDTH-1], bx};
    dy_nxt = {ay[COORD_WIDTH-1], ay} - {by[COORD_WIDTH-1], by};
  end

  // Load the entry stage with guard bits appended
  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= {{(CW-COORD_WIDTH-1-GUARD){dx_nxt[COORD_WIDTH]}}, dx_nxt, {GUARD{1'b0}}};
      y0_r <= {{(CW-COORD_WIDTH-1-GUARD){dy_nxt[COORD_WIDTH]}}, dy_nxt, {GUARD{1'b0}}};
      z0_r <= {z_rot, {(ANGLE_W-HEADING_W){1'b0}}};
    end
  end

  // Shift the valid bits along with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  assign x_c[0] = x0_r;
  assign y_c[0] = y0_r;
  assign z_c[0] = z0_r;

  // Row of rotation cells, one per arctan step
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    ttbf_cell #(
      .W     (CW),
      .STAGE (g)
    ) u_cell (
      .clk   (clk),
      .en    (adv),
      .x_in  (x_c[g]),
      .y_in  (y_c[g]),
      .z_in  (z_c[g]),
      .x_out (x_c[g+1]),
      .y_out (y_c[g+1]),
      .z_out (z_c[g+1])
    );
  end

  // Gain correction for both outputs; lateral takes the negated value
  ttbf_scale #(
    .IN_W   (CW),
    .OUT_W  (OUT_W),
    .GAIN_K (GAIN_K),
    .NEGATE (1'b0)
  ) u_scale_fwd (
    .clk   (clk),
    .en    (adv),
    .d_in  (x_c[ITERATIONS]),
    .q_out (fwd_tail)
  );

  ttbf_scale #(
    .IN_W   (CW),
    .OUT_W  (OUT_W),
    .GAIN_K (GAIN_K),
    .NEGATE (1'b1)
  ) u_scale_lat (
    .clk   (clk),
    .en    (adv),
    .d_in  (y_c[ITERATIONS]),
    .q_out (lat_tail)
  );

  assign tail_v   = vld_r[DEPTH-1];
  assign out_take = out_valid_r && !out_stall;

  // Steer the pipeline tail into the output register or the skid slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_v_nxt    = skid_v_r;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_v_r) begin
      if (out_take) begin
        out_from_skid = 1'b1;
        skid_v_nxt    = 1'b0;
      end
    end else if (!out_valid_r || out_take) begin
      out_valid_nxt = tail_v;
      load_out      = 1'b1;
    end else if (tail_v) begin
      skid_v_nxt = 1'b1;
      load_skid  = 1'b1;
    end
  end

  // Hold output and skid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
    end
  end

  // Hold output and skid data
  always_ff @(posedge clk) begin
    if (out_from_skid) begin
      out_fwd_r <= skid_fwd_r;
      out_lat_r <= skid_lat_r;
    end else if (load_out) begin
      out_fwd_r <= fwd_tail;
      out_lat_r <= lat_tail;
    end
    if (load_skid) begin
      skid_fwd_r <= fwd_tail;
      skid_lat_r <= lat_tail;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_forward_offset = out_fwd_r;
  assign out_lateral_offset = out_lat_r;

  // A parked transaction always sits behind a valid output
  `TTBF_ASSERT(a_skid_behind_out, clk, rst_n, !skid_v_r || out_valid_r)
  // A tail transaction meeting a stalled output goes to the skid slot
  `TTBF_ASSERT_NEXT(a_skid_fill, clk, rst_n, tail_v && !skid_v_r && out_valid_r && out_stall, skid_v_r)
  // A taken output drains the skid slot into the output register
  `TTBF_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_v_r && !out_stall, !skid_v_r && out_valid_r)

endmodule

FILE: hw/rtl/ttbf_cell.sv
// One CORDIC rotation cell: a single arctan step on (x, y, z)
module ttbf_cell #(
  parameter int W     = 36,
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [W-1:0]                 x_in,
  input  logic signed [W-1:0]                 y_in,
  input  logic signed [ttbf_pkg::ANGLE_W-1:0] z_in,
  output logic signed [W-1:0]                 x_out,
  output logic signed [W-1:0]                 y_out,
  output logic signed [ttbf_pkg::ANGLE_W-1:0] z_out
);
  import ttbf_pkg::*;

  localparam logic signed [ANGLE_W-1:0] ATAN = ATAN_UNITS[STAGE];

  logic signed [W-1:0]       x_r, x_nxt;
  logic signed [W-1:0]       y_r, y_nxt;
  logic signed [ANGLE_W-1:0] z_r, z_nxt;
  logic signed [W-1:0]       xs;
  logic signed [W-1:0]       ys;

  // Rotate toward zero residual angle
  always_comb begin
    xs = x_in >>> STAGE;
    ys = y_in >>> STAGE;
    if (!z_in[ANGLE_W-1]) begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end else begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end
  end

  // Hand the result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

FILE: hw/rtl/ttbf_scale.sv
// Gain correction, round to nearest and saturation for one CORDIC output
module ttbf_scale #(
  parameter int          IN_W   = 36,
  parameter int          OUT_W  = 26,
  parameter logic [31:0] GAIN_K = 32'd0,
  parameter bit          NEGATE = 1'b0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [IN_W-1:0]  d_in,
  output logic signed [OUT_W-1:0] q_out
);
  import ttbf_pkg::*;

  localparam int R_W = IN_W - GUARD + 1;
  localparam logic [R_W-1:0]         LIM     = R_W'(1) << (OUT_W - 1);
  localparam logic signed [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [63:0]            HALF_LSB = 64'd1 << (GUARD - 1);

  logic              neg1_r, neg2_r, neg3_r;
  logic [IN_W-1:0]   mag_r, mag_nxt;
  logic [63:0]       mag_ext;
  logic [63:0]       lo_r, hi_r;
  logic [63:0]       t_sum;
  logic [63:0]       t_rnd;
  logic [R_W-1:0]    r_r, r_nxt;
  logic              res_neg;
  logic signed [OUT_W-1:0] q_r, q_nxt;

  // Split into sign and magnitude
  assign mag_nxt = d_in[IN_W-1] ? IN_W'(-d_in) : IN_W'(d_in);
  assign mag_ext = 64'(mag_r);

  // Form floor(m*K/2^32) from two partial products, then round
  always_comb begin
    t_sum = hi_r + (lo_r >> 32);
    t_rnd = t_sum + HALF_LSB;
    r_nxt = R_W'(t_rnd >> GUARD);
  end

  // Apply sign and clamp to the output range
  always_comb begin
    res_neg = neg3_r ^ NEGATE;
    if (res_neg) begin
      q_nxt = (r_r > LIM) ? SAT_MIN : ('0 - OUT_W'(r_r));
    end else begin
      q_nxt = (r_r >= LIM) ? SAT_MAX : OUT_W'(r_r);
    end
  end

  // Advance the four scaling stages
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= d_in[IN_W-1];
      mag_r  <= mag_nxt;
      neg2_r <= neg1_r;
      lo_r   <= 64'(mag_ext[31:0]) * 64'(GAIN_K);
      hi_r   <= 64'(mag_ext[63:32]) * 64'(GAIN_K);
      neg3_r <= neg2_r;
      r_r    <= r_nxt;
      q_r    <= q_nxt;
    end
  end

  assign q_out = q_r;

endmodule
